// ===== rtl/core/block_bitmap_allocator_top_assert.svh =====
// Assertion macros for the block bitmap allocator checker.
// Expects signals named clk and rst in the scope where a macro is used.
`ifndef BLOCK_BITMAP_ALLOCATOR_TOP_ASSERT_SVH
`define BLOCK_BITMAP_ALLOCATOR_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BBA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/bba_pkg.sv =====
// Shared types and constants for the block bitmap allocator.
// Used by the controller, the datapath, the top level and the checker.
`timescale 1ns / 1ps

package bba_pkg;

  localparam int BLOCK_COUNT = 32768;
  localparam int WORD_BITS   = 32;
  localparam int MAP_WORDS   = (BLOCK_COUNT + WORD_BITS - 1) / WORD_BITS;
  localparam int ADDR_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int BIT_W       = $clog2(WORD_BITS);
  localparam int ID_W        = 15;
  localparam int CMD_W       = 2;
  localparam int ST_W        = 2;
  localparam int RES_W       = 16;

  // Width wide enough for block counts, reserved counts and word/bit ids.
  localparam int CNT_A = $clog2(BLOCK_COUNT + 1);
  localparam int CNT_B = (CNT_A > RES_W) ? CNT_A : RES_W;
  localparam int CNT_C = (CNT_B > ID_W) ? CNT_B : ID_W;
  localparam int CNT_W = (CNT_C > ADDR_W + BIT_W) ? CNT_C : ADDR_W + BIT_W;

  localparam logic [CMD_W-1:0] CMD_FORMAT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FREE   = 2'd2;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [ID_W-1:0]  block_id;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0] granted_id;
    logic [ST_W-1:0] status;
  } out_item_t;

  // Controller to datapath.
  typedef struct packed {
    logic            item_load;
    logic            addr_clr;
    logic            addr_inc;
    logic            fmt_load;
    logic            fmt_zero;
    logic            fmt_wr;
    logic            scan_rd;
    logic            cap;
    logic            alloc_wr;
    logic            free_rd;
    logic            free_wr;
    logic            res_set;
    logic            res_grant;
    logic [ST_W-1:0] res_code;
    logic            out_load;
  } ctl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic addr_last;
    logic chk_hit;
    logic chk_last;
    logic chk_vld;
    logic grant_ok;
    logic id_ok;
  } dp_stat_t;

endpackage

// ===== rtl/core/bba_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; no package dependency.
`timescale 1ns / 1ps

module bba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/bba_ctrl.sv =====
// Controller state machine of the block bitmap allocator.
// Depends on bba_pkg for the command and status structs and the codes.
`timescale 1ns / 1ps

module bba_ctrl
  import bba_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [CMD_W-1:0] in_command,
  output logic             in_ready,
  input  logic             out_ready,
  output logic             out_valid,
  input  dp_stat_t         stat,
  output ctl_cmd_t         cmd
);

  typedef enum logic [3:0] {
    S_INIT, S_CLEAR, S_IDLE, S_FMT, S_SCAN, S_GRANT, S_FREE_RD, S_FREE_WR, S_DONE
  } state_t;

  state_t state, state_next;
  logic   issued, issued_next;
  logic   out_valid_next;
  logic   slot_free;

  assign in_ready  = (state == S_IDLE);
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    cmd            = '0;
    cmd.res_code   = ST_OK;
    state_next     = state;
    issued_next    = issued;
    out_valid_next = out_valid;
    if (out_ready) begin
      out_valid_next = 1'b0;
    end
    unique case (state)
      S_INIT: begin
        cmd.addr_clr = 1'b1;
        cmd.fmt_load = 1'b1;
        cmd.fmt_zero = 1'b1;
        state_next   = S_CLEAR;
      end
      S_CLEAR: begin
        cmd.fmt_wr   = 1'b1;
        cmd.addr_inc = 1'b1;
        if (stat.addr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.item_load = 1'b1;
          cmd.addr_clr  = 1'b1;
          priority if (in_command == CMD_FORMAT) begin
            cmd.fmt_load = 1'b1;
            state_next   = S_FMT;
          end else if (in_command == CMD_ALLOC) begin
            issued_next = 1'b0;
            state_next  = S_SCAN;
          end else if (in_command == CMD_FREE) begin
            state_next = S_FREE_RD;
          end else begin
            cmd.res_set = 1'b1;
            state_next  = S_DONE;
          end
        end
      end
      S_FMT: begin
        cmd.fmt_wr   = 1'b1;
        cmd.addr_inc = 1'b1;
        if (stat.addr_last) begin
          cmd.res_set = 1'b1;
          state_next  = S_DONE;
        end
      end
      S_SCAN: begin
        cmd.scan_rd  = !issued;
        cmd.addr_inc = !issued && !stat.addr_last;
        if (!issued && stat.addr_last) begin
          issued_next = 1'b1;
        end
        if (stat.chk_hit) begin
          cmd.cap    = 1'b1;
          state_next = S_GRANT;
        end else if (stat.chk_vld && stat.chk_last) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = ST_FULL;
          state_next   = S_DONE;
        end
      end
      S_GRANT: begin
        cmd.res_set = 1'b1;
        if (stat.grant_ok) begin
          cmd.alloc_wr  = 1'b1;
          cmd.res_grant = 1'b1;
        end else begin
          cmd.res_code = ST_FULL;
        end
        state_next = S_DONE;
      end
      S_FREE_RD: begin
        if (stat.id_ok) begin
          cmd.free_rd = 1'b1;
          state_next  = S_FREE_WR;
        end else begin
          cmd.res_set  = 1'b1;
          cmd.res_code = ST_RANGE;
          state_next   = S_DONE;
        end
      end
      S_FREE_WR: begin
        cmd.free_wr = 1'b1;
        cmd.res_set = 1'b1;
        state_next  = S_DONE;
      end
      S_DONE: begin
        if (slot_free) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      issued    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      issued    <= issued_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ===== rtl/core/bba_dpath.sv =====
// Datapath of the block bitmap allocator: usage map RAM, counters, result registers.
// Depends on bba_pkg and instantiates bba_ram.
`timescale 1ns / 1ps

module bba_dpath
  import bba_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [RES_W-1:0] cfg_wr_data,
  input  in_item_t         in_data,
  input  ctl_cmd_t         cmd,
  output dp_stat_t         stat,
  output out_item_t        out_data
);

  localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(MAP_WORDS - 1);
  localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(BLOCK_COUNT);

  function automatic logic [BIT_W-1:0] low_free(input logic [WORD_BITS-1:0] w);
    logic [WORD_BITS-1:0] avail;
    logic [WORD_BITS-1:0] low;
    logic [BIT_W-1:0]     idx;
    avail = ~w;
    low   = avail & (~avail + WORD_BITS'(1));
    idx   = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (low[i]) begin
        idx = idx | BIT_W'(i);
      end
    end
    return idx;
  endfunction

  logic [RES_W-1:0]     res_cnt;
  logic [ID_W-1:0]      blk_id;
  logic [ADDR_W-1:0]    addr;
  logic [CNT_W-1:0]     fmt_cnt;
  logic                 rd_vld;
  logic [ADDR_W-1:0]    rd_addr;
  logic [WORD_BITS-1:0] hold_word;
  logic [ADDR_W-1:0]    hold_addr;
  logic [BIT_W-1:0]     hold_bit;
  out_item_t            res_pend;

  logic [WORD_BITS-1:0] rdata;
  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic                 ram_re;
  logic [ADDR_W-1:0]    ram_raddr;

  logic [CNT_W-1:0]     res_ext;
  logic [CNT_W-1:0]     res_sat;
  logic [CNT_W-1:0]     id_ext;
  logic [ADDR_W-1:0]    id_word;
  logic [BIT_W-1:0]     id_bit;
  logic [CNT_W-1:0]     hold_id;
  logic [CNT_W-1:0]     addr_ext;
  logic [CNT_W-1:0]     fmt_full;
  logic [BIT_W-1:0]     fmt_rem;
  logic [WORD_BITS-1:0] rem_mask;
  logic [WORD_BITS-1:0] fmt_word;

  assign res_ext = CNT_W'(res_cnt);
  assign res_sat = (res_ext > CNT_MAX) ? CNT_MAX : res_ext;
  assign id_ext  = CNT_W'(blk_id);
  assign id_word = id_ext[BIT_W +: ADDR_W];
  assign id_bit  = blk_id[BIT_W-1:0];
  assign hold_id = CNT_W'({hold_addr, hold_bit});

  // Format word: full below the reserved boundary, partial on it, empty above.
  assign addr_ext = CNT_W'(addr);
  assign fmt_full = fmt_cnt >> BIT_W;
  assign fmt_rem  = fmt_cnt[BIT_W-1:0];

  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      rem_mask[i] = (BIT_W'(i) < fmt_rem);
    end
    if (addr_ext < fmt_full) begin
      fmt_word = '1;
    end else if (addr_ext == fmt_full) begin
      fmt_word = rem_mask;
    end else begin
      fmt_word = '0;
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr;
    ram_wdata = fmt_word;
    priority if (cmd.fmt_wr) begin
      ram_we = 1'b1;
    end else if (cmd.alloc_wr) begin
      ram_we    = 1'b1;
      ram_waddr = hold_addr;
      ram_wdata = hold_word | (WORD_BITS'(1) << hold_bit);
    end else if (cmd.free_wr) begin
      ram_we    = 1'b1;
      ram_waddr = id_word;
      ram_wdata = rdata & ~(WORD_BITS'(1) << id_bit);
    end
    ram_re    = cmd.scan_rd || cmd.free_rd;
    ram_raddr = cmd.free_rd ? id_word : addr;
  end

  bba_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(MAP_WORDS)
  ) u_map (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(rdata)
  );

  assign stat.addr_last = (addr == ADDR_LAST);
  assign stat.chk_vld   = rd_vld;
  assign stat.chk_hit   = rd_vld && (~rdata != '0);
  assign stat.chk_last  = (rd_addr == ADDR_LAST);
  assign stat.grant_ok  = (hold_id < CNT_MAX);
  assign stat.id_ok     = (id_ext < CNT_MAX);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_cnt <= '0;
      rd_vld  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        res_cnt <= cfg_wr_data;
      end
      rd_vld <= cmd.scan_rd;
    end
  end

  always_ff @(posedge clk) begin
    rd_addr <= addr;
    if (cmd.item_load) begin
      blk_id <= in_data.block_id;
    end
    if (cmd.addr_clr) begin
      addr <= '0;
    end else if (cmd.addr_inc) begin
      addr <= addr + ADDR_W'(1);
    end
    if (cmd.fmt_load) begin
      fmt_cnt <= cmd.fmt_zero ? '0 : res_sat;
    end
    if (cmd.cap) begin
      hold_word <= rdata;
      hold_addr <= rd_addr;
      hold_bit  <= low_free(rdata);
    end
    if (cmd.res_set) begin
      res_pend.status     <= cmd.res_code;
      res_pend.granted_id <= cmd.res_grant ? hold_id[ID_W-1:0] : '0;
    end
    if (cmd.out_load) begin
      out_data <= res_pend;
    end
  end

endmodule

// ===== rtl/core/block_bitmap_allocator_top.sv =====
// Processing: free reads and rewrites one map word, format writes every map word, and
// allocate scans the map word by word until it finds a free bit or reaches the last word.
// Throughput: one item at a time; a new item is accepted only once the last result is in the output register.
// Reset: synchronous, active high; afterwards a clearing pass writes every map word to zero,
// during which in_ready stays low.
// Depends on bba_pkg, bba_ctrl and bba_dpath.
`timescale 1ns / 1ps

module block_bitmap_allocator_top
  import bba_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [RES_W-1:0] cfg_wr_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data
);

  // The controller decides the sequence of RAM sweeps and result updates; the
  // datapath owns the usage map, the address counter and all payload registers.
  // The two talk only through the command and status structs below.
  ctl_cmd_t cmd;
  dp_stat_t stat;

  // The controller sees the command field at the accepting beat so that it can
  // branch straight from idle into the matching sweep or lookup.
  bba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_command(in_data.command),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .stat      (stat),
    .cmd       (cmd)
  );

  // A finished result waits in the output register; the next input beat is
  // accepted while it waits, and only the following result stalls on it.
  bba_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_data    (in_data),
    .cmd        (cmd),
    .stat       (stat),
    .out_data   (out_data)
  );

endmodule

// ===== rtl/core/bba_checker.sv =====
// Port-level checker for the block bitmap allocator, bound to the top level.
// Depends on bba_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "block_bitmap_allocator_top_assert.svh"

module bba_checker
  import bba_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  `BBA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result beat dropped or changed while stalled")
  `BBA_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "second beat accepted while an item is in work")
  `BBA_ASSERT_SAME(a_no_grant, out_valid && (out_data.status != ST_OK), out_data.granted_id == '0, "failed command reports a granted block")
  `BBA_ASSERT_SAME(a_clear, $past(rst), !in_ready, "input accepted before the map clearing pass")

endmodule

bind block_bitmap_allocator_top bba_checker u_bba_checker (.*);

// ===== tb/bba_reply_checker.sv =====
// Reply checker for the block bitmap allocator: watches the config port and both channels,
// keeps its own copy of the usage map and compares every reply beat with its prediction.
// Depends on bba_pkg.
`timescale 1ns / 1ps

module bba_reply_checker
  import bba_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [RES_W-1:0] cfg_wr_data,
  input  logic             in_valid,
  input  logic             in_ready,
  input  in_item_t         in_data,
  input  logic             out_valid,
  input  logic             out_ready,
  input  out_item_t        out_data,
  output int               outstanding,
  output int               fails
);

  logic [WORD_BITS-1:0] usage_words [MAP_WORDS];
  logic [RES_W-1:0]     reserved_blocks;
  out_item_t            replies_due [$];

  initial begin
    outstanding = 0;
    fails = 0;
  end

  task automatic report(input string msg);
    $display("[%0t] bba check: %s", $time, msg);
    fails++;
  endtask

  // Applies one command to the local map and returns the reply it should give.
  function automatic out_item_t serve_request(input in_item_t req);
    out_item_t   reply;
    int unsigned keep;
    int unsigned id;
    int          w;
    int          b;
    logic        found;
    reply = '0;
    reply.status = ST_OK;
    case (req.command)
      CMD_FORMAT: begin
        keep = (reserved_blocks > BLOCK_COUNT) ? BLOCK_COUNT : reserved_blocks;
        for (w = 0; w < MAP_WORDS; w++) begin
          if ((w + 1) * WORD_BITS <= keep) begin
            usage_words[w] = '1;
          end else if (w * WORD_BITS < keep) begin
            usage_words[w] = {WORD_BITS{1'b1}} >> (WORD_BITS - (keep - w * WORD_BITS));
          end else begin
            usage_words[w] = '0;
          end
        end
      end
      CMD_ALLOC: begin
        found = 1'b0;
        for (w = 0; w < MAP_WORDS && !found; w++) begin
          if (~usage_words[w] != '0) begin
            b = 0;
            while (usage_words[w][b]) b++;
            found = 1'b1;
            id = w * WORD_BITS + b;
            if (id < BLOCK_COUNT) begin
              usage_words[w][b] = 1'b1;
              reply.granted_id = ID_W'(id);
            end else begin
              reply.status = ST_FULL;
            end
          end
        end
        if (!found) reply.status = ST_FULL;
      end
      CMD_FREE: begin
        if (int'(req.block_id) >= BLOCK_COUNT) begin
          reply.status = ST_RANGE;
        end else begin
          usage_words[req.block_id / WORD_BITS][req.block_id % WORD_BITS] = 1'b0;
        end
      end
      default: ;
    endcase
    return reply;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      for (int w = 0; w < MAP_WORDS; w++) usage_words[w] = '0;
      reserved_blocks = '0;
      replies_due.delete();
    end else begin
      if (cfg_wr_en) reserved_blocks = cfg_wr_data;
      if (out_valid && out_ready) begin
        if (replies_due.size() == 0) begin
          report($sformatf("reply with nothing pending: id %0d status %0d",
                           out_data.granted_id, out_data.status));
        end else begin
          want = replies_due.pop_front();
          if (out_data.granted_id !== want.granted_id)
            report($sformatf("granted_id %0d, predicted %0d",
                             out_data.granted_id, want.granted_id));
          if (out_data.status !== want.status)
            report($sformatf("status %0d, predicted %0d", out_data.status, want.status));
        end
      end
      if (in_valid && in_ready) replies_due.push_back(serve_request(in_data));
    end
    outstanding = replies_due.size();
  end

endmodule

// ===== tb/tb_top.sv =====
// Top of the block bitmap allocator testbench: clock, reset, stimulus and verdict.
// Depends on bba_pkg, block_bitmap_allocator_top and bba_reply_checker.
`timescale 1ns / 1ps

module tb_top;
  import bba_pkg::*;

  // The package names no code for the spare command value, so it is named here.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int ID_MAX = (1 << ID_W) - 1;

  // Reserved counts at or above this make every allocation sweep most of the map, so
  // phases with such settings are kept short.
  localparam int SLOW_RESERVE = 30000;

  // The timeout is taken from the slowest correct run: every beat a full-map sweep, the
  // longest receiver stall and the longest sender gap, plus the clearing pass after reset,
  // and then several times over.
  localparam int ITEM_BOUND   = 600;
  localparam int SLOWEST_BEAT = MAP_WORDS + 5 + 8 + 16;
  localparam int CYCLE_LIMIT  = 4 * (ITEM_BOUND * SLOWEST_BEAT + 2 * (MAP_WORDS + 1));

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_wr_en = 1'b0;
  logic [RES_W-1:0] cfg_wr_data = '0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  in_item_t         in_data = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_item_t        out_data;

  int outstanding;
  int fails;
  int cycles = 0;
  int burst_left = 0;
  int stall_left = 0;

  always #4 clk = ~clk;

  block_bitmap_allocator_top dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  bba_reply_checker reply_chk (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .outstanding(outstanding),
    .fails      (fails)
  );

  // The receiver switches at random between ready runs and stalls, so back-pressure
  // lands on every phase of the block's work.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 9) < 6) begin
      out_ready  <= 1'b1;
      stall_left <= $urandom_range(0, 24);
    end else begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 7);
    end
  end

  // Watchdog: a hung block ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("block_bitmap_allocator_top: mismatch");
      $finish;
    end
  end

  // Sends one beat and returns in the time step in which it is accepted. Beats go out in
  // bursts; between bursts the sender may sit idle, and a burst that
  // follows with no gap keeps valid high throughout.
  task automatic push_item(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id);
    int       gap;
    in_item_t beat;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    beat.command  = cmd;
    beat.block_id = id;
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (!in_ready);
    burst_left--;
  endtask

  // Holds the sender off until every predicted reply has come back. The pending count is
  // looked at on the falling edge so that it never races the checker's update.
  task automatic pause_sender();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(negedge clk); while (outstanding != 0);
    @(posedge clk);
  endtask

  // Called once during the clearing pass after reset, and otherwise only while the block is idle.
  task automatic write_reserved(input logic [RES_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Free targets mostly land near the formatted region, where blocks are actually in use;
  // the rest sit at the top of the id range or anywhere, so every id bit toggles.
  function automatic logic [ID_W-1:0] pick_block(input int unsigned res);
    int unsigned roll;
    int unsigned reach;
    roll  = $urandom_range(0, 99);
    reach = (res + 80 > ID_MAX) ? ID_MAX : res + 80;
    if (roll < 70) return ID_W'($urandom_range(0, reach));
    else if (roll < 85) return ID_W'(ID_MAX - $urandom_range(0, 40));
    else return ID_W'($urandom_range(0, ID_MAX));
  endfunction

  initial begin
    int unsigned settings [11];
    int unsigned res;
    int          count;
    int          roll;

    settings = '{0, 1, 31, 32, 33, 500, 2000, 32767, 32768, 65535, 0};

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    write_reserved(16'd0);

    // Directed part. The map is clear after reset, so the first grants come from block
    // zero upwards; a freed block is reused before anything higher.
    push_item(CMD_ALLOC, ID_W'(ID_MAX));
    push_item(CMD_ALLOC, '0);
    push_item(CMD_FREE, '0);
    push_item(CMD_FREE, '0);            // freeing a block that is already free
    push_item(CMD_ALLOC, '0);
    push_item(CMD_FREE, ID_W'(ID_MAX)); // highest id, never used
    push_item(CMD_UNUSED, ID_W'(ID_MAX));
    push_item(CMD_FORMAT, '0);
    push_item(CMD_ALLOC, '0);

    // A reserved count above the block count saturates, so format fills the whole map.
    pause_sender();
    write_reserved(16'hFFFF);
    push_item(CMD_FORMAT, ID_W'(ID_MAX));
    push_item(CMD_ALLOC, '0);           // map full
    push_item(CMD_FREE, ID_W'(ID_MAX));
    push_item(CMD_ALLOC, '0);           // takes the last block back
    push_item(CMD_ALLOC, '0);           // full again
    push_item(CMD_FREE, ID_W'(12345));
    push_item(CMD_ALLOC, '0);

    // All but the last block reserved.
    pause_sender();
    write_reserved(16'd32767);
    push_item(CMD_FORMAT, '0);
    push_item(CMD_ALLOC, '0);
    push_item(CMD_ALLOC, '0);

    // A reserved count that ends part-way through a map word.
    pause_sender();
    write_reserved(16'd33);
    push_item(CMD_FORMAT, '0);
    push_item(CMD_ALLOC, '0);
    push_item(CMD_FREE, '0);
    push_item(CMD_ALLOC, '0);

    // Random part: each phase sets a reserved count, formats and then runs a mix of
    // allocations, frees, the odd re-format and the spare command. Halfway through each
    // phase the sender drains the block before carrying on.
    foreach (settings[p]) begin
      res = (p == 10) ? $urandom_range(0, 3000) : settings[p];
      pause_sender();
      write_reserved(RES_W'(res));
      count = (res >= SLOW_RESERVE) ? 12 : 57;
      push_item(CMD_FORMAT, ID_W'($urandom_range(0, ID_MAX)));
      for (int k = 1; k < count; k++) begin
        if (k == count / 2) pause_sender();
        roll = $urandom_range(0, 99);
        if (roll < 45) push_item(CMD_ALLOC, ID_W'($urandom_range(0, ID_MAX)));
        else if (roll < 80) push_item(CMD_FREE, pick_block(res));
        else if (roll < 90) push_item(CMD_FORMAT, ID_W'($urandom_range(0, ID_MAX)));
        else push_item(CMD_UNUSED, ID_W'($urandom_range(0, ID_MAX)));
      end
    end

    // Wait for the last reply, then keep watching to catch stray beats.
    pause_sender();
    repeat (MAP_WORDS + 8) @(posedge clk);
    if (fails == 0) begin
      $display("block_bitmap_allocator_top: match");
    end else begin
      $display("block_bitmap_allocator_top: mismatch");
    end
    $finish;
  end

endmodule

// ===== block_bitmap_allocator_top.f =====
+incdir+rtl/core
rtl/core/bba_pkg.sv
rtl/core/bba_ram.sv
rtl/core/bba_ctrl.sv
rtl/core/bba_dpath.sv
rtl/core/block_bitmap_allocator_top.sv
rtl/core/bba_checker.sv
tb/bba_reply_checker.sv
tb/tb_top.sv
